[src/olid_pkg.sv]
package olid_pkg;

   localparam int VALUE_W          = 32;
   localparam int POS_W            = 6;
   localparam int MODE_W           = 2;
   localparam int CAPACITY_DEFAULT = 32;

   localparam logic [MODE_W-1:0] MODE_INSERT_FRONT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT_BACK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE       = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT,
      CELL_FROM_HEAD
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

endpackage

[src/ordered_list_insert_delete_top.sv]
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells, one entry per
// cell. A request beat inserts at the front, inserts at the back or removes at a position;
// the edit is applied to the cells in the cycle the beat is accepted. The whole list then
// leaves as one response beat per entry, front first, tlast on the final one; an empty list
// gives a single beat flagged empty, and an insert into a full list sets the dropped flag on
// every beat. Each beat is taken from the head cell while the occupied cells rotate by one;
// no new request is taken until the last beat has been handed to the output register.
module ordered_list_insert_delete_top #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[37:32], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // entry_value[31:0]
   output logic [1:0]  rsp_tuser,   // list_empty[0], dropped[1]
   output logic        rsp_tlast
);
   import olid_pkg::*;

   cell_op_type               cell_op [CAPACITY];
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic signed [VALUE_W-1:0] load_value;
   logic signed [VALUE_W-1:0] rsp_value;
   logic                      rsp_empty;
   logic                      rsp_dropped;

   assign load_value = req_tdata[VALUE_W-1:0];

   olid_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_mode     (req_tuser),
      .req_position (req_tdata[VALUE_W+POS_W-1:VALUE_W]),
      .head_value   (cell_value[0]),
      .cell_op      (cell_op),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_empty    (rsp_empty),
      .rsp_dropped  (rsp_dropped),
      .rsp_last     (rsp_tlast)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value;
      logic signed [VALUE_W-1:0] next_value;

      if (i == 0) begin : g_first
         assign prev_value = load_value;
      end else begin : g_mid_prev
         assign prev_value = cell_value[i-1];
      end

      // tail cell has no neighbour behind it
      if (i == CAPACITY - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_mid_next
         assign next_value = cell_value[i+1];
      end

      olid_cell u_cell (
         .clock      (clock),
         .op         (cell_op[i]),
         .load_value (load_value),
         .prev_value (prev_value),
         .next_value (next_value),
         .head_value (cell_value[0]),
         .value      (cell_value[i])
      );
   end

   assign rsp_tdata = rsp_value;
   assign rsp_tuser = {rsp_dropped, rsp_empty};

endmodule

[src/olid_cell.sv]
module olid_cell (
   input  logic                              clock,
   input  olid_pkg::cell_op_type             op,
   input  logic signed [olid_pkg::VALUE_W-1:0] load_value,
   input  logic signed [olid_pkg::VALUE_W-1:0] prev_value,
   input  logic signed [olid_pkg::VALUE_W-1:0] next_value,
   input  logic signed [olid_pkg::VALUE_W-1:0] head_value,
   output logic signed [olid_pkg::VALUE_W-1:0] value
);
   import olid_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      case (op)
         CELL_HOLD:      value_in = value_ff;
         CELL_LOAD:      value_in = load_value;
         CELL_FROM_PREV: value_in = prev_value;
         CELL_FROM_NEXT: value_in = next_value;
         CELL_FROM_HEAD: value_in = head_value;
         default:        value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[src/olid_ctrl.sv]
module olid_ctrl #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [olid_pkg::MODE_W-1:0]          req_mode,
   input  logic [olid_pkg::POS_W-1:0]           req_position,
   input  logic signed [olid_pkg::VALUE_W-1:0]  head_value,
   output olid_pkg::cell_op_type                cell_op [CAPACITY],
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic signed [olid_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                 rsp_empty,
   output logic                                 rsp_dropped,
   output logic                                 rsp_last
);
   import olid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   emit_idx_ff, emit_idx_in;
   logic               drop_ff, drop_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_dropped_ff, rsp_dropped_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               out_free;
   logic               last_beat;
   logic               is_full;
   logic               pos_hit;
   logic [CNT_W-1:0]   emit_next;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   count_ext;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign pos_ext   = CMP_W'(req_position);
   assign count_ext = CMP_W'(count_ff);
   assign pos_hit   = (pos_ext < count_ext);
   assign emit_next = CNT_W'(emit_idx_ff + 1'b1);
   assign last_beat = (count_ff == '0) || (emit_next == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && last_beat) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs, cell commands and counters
   always_comb begin
      req_tready     = 1'b0;
      count_in       = count_ff;
      emit_idx_in    = emit_idx_ff;
      drop_in        = drop_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_last_in    = rsp_last_ff;
      for (int i = 0; i < CAPACITY; i++) cell_op[i] = CELL_HOLD;

      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            emit_idx_in = '0;
            if (accept) begin
               drop_in = 1'b0;
               case (req_mode)
                  MODE_INSERT_FRONT: begin
                     if (is_full) begin
                        drop_in = 1'b1;
                     end else begin
                        for (int i = 0; i < CAPACITY; i++)
                           cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  MODE_INSERT_BACK: begin
                     if (is_full) begin
                        drop_in = 1'b1;
                     end else begin
                        for (int i = 0; i < CAPACITY; i++)
                           if (CNT_W'(i) == count_ff) cell_op[i] = CELL_LOAD;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  MODE_REMOVE: begin
                     if (pos_hit) begin
                        for (int i = 0; i < CAPACITY; i++)
                           if (CMP_W'(i) >= pos_ext) cell_op[i] = CELL_FROM_NEXT;
                        count_in = CNT_W'(count_ff - 1'b1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_dropped_in = drop_ff;
               rsp_last_in    = last_beat;
               if (count_ff == '0) begin
                  rsp_value_in = '0;
                  rsp_empty_in = 1'b1;
               end else begin
                  rsp_value_in = head_value;
                  rsp_empty_in = 1'b0;
                  emit_idx_in  = emit_next;
                  // rotate the held entries by one so the next one reaches the head
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (CNT_W'(i + 1) == count_ff)    cell_op[i] = CELL_FROM_HEAD;
                     else if (CNT_W'(i + 1) < count_ff) cell_op[i] = CELL_FROM_NEXT;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         emit_idx_ff  <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         emit_idx_ff  <= emit_idx_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff   <= rsp_value_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_empty   = rsp_empty_ff;
   assign rsp_dropped = rsp_dropped_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

[bench/ordered_list_insert_delete_top_tb.sv]
`timescale 1ns / 1ps

module ordered_list_insert_delete_top_tb;
   import olid_pkg::*;

   localparam int          LIST_CAP      = CAPACITY_DEFAULT;
   localparam int          RANDOM_ITEMS  = 260;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          STALL_LIMIT   = 5000;
   localparam int          SETTLE_CYCLES = LIST_CAP + 8;
   localparam logic [1:0]  MODE_UNUSED   = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] entry;
      logic               list_empty;
      logic               dropped;
      logic               last;
   } listing_beat_type;

   // shadow copy of the list; every accepted request queues the listing it must produce
   class list_shadow_type;
      logic [VALUE_W-1:0] entries [LIST_CAP];
      int unsigned        entry_count;
      listing_beat_type   listing_due [$];
      int unsigned        errors, requests, beats_seen, refusals, removals, peak;

      task report_mismatch(string what);
         $display("error at %0t: %s", $time, what);
         errors++;
      endtask

      function void apply_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                                  logic [POS_W-1:0] position);
         bit               refused;
         listing_beat_type beat;
         refused = 1'b0;
         requests++;
         if (mode == MODE_INSERT_FRONT || mode == MODE_INSERT_BACK) begin
            if (entry_count >= LIST_CAP) begin
               refused = 1'b1;
               refusals++;
            end else if (mode == MODE_INSERT_FRONT) begin
               for (int i = entry_count; i > 0; i--)
                  entries[i] = entries[i-1];
               entries[0] = value;
               entry_count++;
            end else begin
               entries[entry_count] = value;
               entry_count++;
            end
         end else if (mode == MODE_REMOVE) begin
            if (position < entry_count) begin
               for (int i = position; i + 1 < entry_count; i++)
                  entries[i] = entries[i+1];
               entry_count--;
               removals++;
            end
         end
         if (entry_count > peak)
            peak = entry_count;
         if (entry_count == 0) begin
            beat.entry      = '0;
            beat.list_empty = 1'b1;
            beat.dropped    = refused;
            beat.last       = 1'b1;
            listing_due.push_back(beat);
         end else begin
            for (int i = 0; i < entry_count; i++) begin
               beat.entry      = entries[i];
               beat.list_empty = 1'b0;
               beat.dropped    = refused;
               beat.last       = (i == entry_count - 1);
               listing_due.push_back(beat);
            end
         end
      endfunction

      task compare_entry(logic [VALUE_W-1:0] entry, logic list_empty, logic dropped,
                         logic last);
         listing_beat_type due;
         beats_seen++;
         if (listing_due.size() == 0) begin
            report_mismatch($sformatf("response beat %h with nothing outstanding", entry));
            return;
         end
         due = listing_due.pop_front();
         if (entry !== due.entry)
            report_mismatch($sformatf("entry %h, wanted %h", entry, due.entry));
         if (list_empty !== due.list_empty)
            report_mismatch($sformatf("empty flag %b, wanted %b", list_empty, due.list_empty));
         if (dropped !== due.dropped)
            report_mismatch($sformatf("dropped flag %b, wanted %b", dropped, due.dropped));
         if (last !== due.last)
            report_mismatch($sformatf("tlast %b, wanted %b", last, due.last));
      endtask
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // value[31:0], position[37:32], zero pad
   logic [1:0]  req_tuser  = '0;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // entry_value[31:0]
   logic [1:0]  rsp_tuser;         // list_empty[0], dropped[1]
   logic        rsp_tlast;

   list_shadow_type shadow = new();
   bit          calm = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned holds_granted = 0;
   int unsigned quiet_cycles  = 0;

   ordered_list_insert_delete_top #(
      .CAPACITY (LIST_CAP)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // responses are checked before the request of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            shadow.compare_entry(rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
         if (req_tvalid && req_tready)
            shadow.apply_request(req_tuser, req_tdata[31:0], req_tdata[37:32]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: %0d cycles without a beat", quiet_cycles);
         $display("ordered_list_insert_delete_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, plus a long hold-off whenever the sender asks for one
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_granted != hold_requests) begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 9);
         end
      end
   end

   task automatic send_request(input logic [1:0] mode, input logic [31:0] value,
                               input logic [5:0] position);
      if (!calm && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, position, value};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      do @(posedge clock);
      while (shadow.listing_due.size() != 0);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(11))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [5:0] pick_position(int unsigned count);
      int unsigned r;
      r = $urandom_range(9);
      if (count == 0 || r >= 8)
         return 6'($urandom_range(63));
      if (r == 7)
         return 6'(count);
      return 6'($urandom_range(count - 1));
   endfunction

   initial begin
      int unsigned insert_pct;
      int unsigned phase;
      logic [1:0]  mode;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: removal and the unused code
      send_request(MODE_REMOVE, 32'h0, 6'd0);
      send_request(MODE_UNUSED, 32'hdead_beef, 6'd17);
      // field extremes at both ends of the list
      send_request(MODE_INSERT_BACK,  32'h7fff_ffff, 6'd0);
      send_request(MODE_INSERT_FRONT, 32'h8000_0000, 6'd63);
      send_request(MODE_INSERT_BACK,  32'h0000_0000, 6'd0);
      send_request(MODE_INSERT_FRONT, 32'hffff_ffff, 6'd0);
      send_request(MODE_INSERT_BACK,  32'h5555_5555, 6'd21);
      send_request(MODE_INSERT_FRONT, 32'haaaa_aaaa, 6'd42);
      // removal beyond the end and exactly at the length leave the list alone
      send_request(MODE_REMOVE, 32'hffff_ffff, 6'd63);
      send_request(MODE_REMOVE, 32'h0, 6'd6);
      send_request(MODE_UNUSED, 32'h1234_5678, 6'd0);
      // last, first, middle, then empty it out
      send_request(MODE_REMOVE, 32'h0, 6'd5);
      send_request(MODE_REMOVE, 32'h0, 6'd0);
      send_request(MODE_REMOVE, 32'h0, 6'd2);
      send_request(MODE_REMOVE, 32'h0, 6'd0);
      send_request(MODE_REMOVE, 32'h0, 6'd0);
      send_request(MODE_REMOVE, 32'h0, 6'd0);
      send_request(MODE_REMOVE, 32'h0, 6'd0);
      send_request(MODE_INSERT_FRONT, 32'h0000_0001, 6'd0);
      send_request(MODE_INSERT_BACK,  32'h1234_5678, 6'd0);

      req_tvalid <= 1'b0;
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 20)
            calm <= 1'b1;
         if (n == 75)
            calm <= 1'b0;
         if (n == 95 || n == 210)
            hold_requests++;
         if (n == 160) begin
            req_tvalid <= 1'b0;
            wait_for_drain();
         end

         // grow until full, then alternate shrinking, regrowing and mixed traffic
         phase = (n < 50) ? 1 : ((n - 50) / 40) % 3;
         case (phase)
            0:       insert_pct = 20;
            1:       insert_pct = 92;
            default: insert_pct = 50;
         endcase

         if ($urandom_range(99) < 2)
            mode = MODE_UNUSED;
         else if ($urandom_range(99) < insert_pct)
            mode = $urandom_range(1) ? MODE_INSERT_BACK : MODE_INSERT_FRONT;
         else
            mode = MODE_REMOVE;
         send_request(mode, pick_value(), pick_position(shadow.entry_count));
      end

      req_tvalid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d response beats: %0d refused inserts,",
               shadow.requests, shadow.beats_seen, shadow.refusals);
      $display("%0d removals applied, longest list %0d of %0d entries",
               shadow.removals, shadow.peak, LIST_CAP);
      if (shadow.errors == 0 && shadow.listing_due.size() == 0) begin
         $display("ordered_list_insert_delete_top: match");
      end else begin
         $display("ordered_list_insert_delete_top: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
src/olid_pkg.sv
src/olid_cell.sv
src/olid_ctrl.sv
src/ordered_list_insert_delete_top.sv
bench/ordered_list_insert_delete_top_tb.sv
